### hw/rtl/eps_pkg.sv
package eps_pkg;

    localparam int CAPTURE_WIDTH = 16;
    localparam int DATA_W        = 32;
    localparam int TCLK_W        = 28;
    localparam int RELOAD_W      = 16;
    localparam int FREQ_W        = 20;
    localparam int ADDR_W        = 4;
    localparam int TICK_LOSS     = 3;

    // multiplier digits: reload bits plus a sign bit for reload below three
    localparam int MUL_STEPS  = RELOAD_W + 1;
    localparam int DIV_STEPS  = TCLK_W;
    localparam int STEP_CNT_W = $clog2((MUL_STEPS > DIV_STEPS) ? MUL_STEPS : DIV_STEPS);

    localparam logic [TCLK_W-1:0]   TCLK_RESET   = TCLK_W'(1000000);
    localparam logic [RELOAD_W-1:0] RELOAD_RESET = RELOAD_W'(65535);
    localparam logic [FREQ_W-1:0]   LIMIT_RESET  = FREQ_W'(20000);

    typedef enum logic [1:0] {
        CMD_OVERFLOW = 2'd0,
        CMD_CAPTURE  = 2'd1,
        CMD_SAMPLE   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_TIMER_CLOCK = 2'd0,
        REG_RELOAD      = 2'd1,
        REG_FREQ_LIMIT  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] ovf_delta;
        logic [DATA_W-1:0] cap_delta;
        logic              chan_b;
        logic [DATA_W-1:0] position_next;
    } eps_snap_t;

endpackage

### hw/rtl/eps_track.sv
module eps_track
    import eps_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     ev_accept,
    input  logic [1:0]               cmd,
    input  logic [CAPTURE_WIDTH-1:0] capture_time,
    input  logic                     chan_b_level,
    output eps_snap_t                snap
);

    logic [DATA_W-1:0]        overflow_count_reg;
    logic [CAPTURE_WIDTH-1:0] prev_capture_reg;
    logic [CAPTURE_WIDTH-1:0] last_capture_reg;
    logic [DATA_W-1:0]        prev_overflows_reg;
    logic [DATA_W-1:0]        last_overflows_reg;
    logic                     latched_chan_b_reg;
    logic [DATA_W-1:0]        edge_count_reg;
    logic [DATA_W-1:0]        position_acc_reg;
    logic [DATA_W-1:0]        position_next;

    assign position_next = latched_chan_b_reg ? position_acc_reg + edge_count_reg
                                              : position_acc_reg - edge_count_reg;

    always_comb
    begin
        snap.ovf_delta     = last_overflows_reg - prev_overflows_reg;
        snap.cap_delta     = DATA_W'(last_capture_reg) - DATA_W'(prev_capture_reg);
        snap.chan_b        = latched_chan_b_reg;
        snap.position_next = position_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overflow_count_reg <= '0;
            prev_capture_reg   <= '0;
            last_capture_reg   <= '0;
            prev_overflows_reg <= '0;
            last_overflows_reg <= '0;
            latched_chan_b_reg <= 1'b0;
            edge_count_reg     <= '0;
            position_acc_reg   <= '0;
        end
        else if (ev_accept)
        begin
            case (cmd_t'(cmd))
                CMD_OVERFLOW:
                begin
                    overflow_count_reg <= overflow_count_reg + 1'b1;
                end
                CMD_CAPTURE:
                begin
                    prev_capture_reg   <= last_capture_reg;
                    last_capture_reg   <= capture_time;
                    prev_overflows_reg <= last_overflows_reg;
                    last_overflows_reg <= overflow_count_reg;
                    latched_chan_b_reg <= chan_b_level;
                    edge_count_reg     <= edge_count_reg + 1'b1;
                end
                CMD_SAMPLE:
                begin
                    position_acc_reg <= position_next;
                    edge_count_reg   <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

### hw/rtl/eps_mul.sv
module eps_mul
    import eps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DATA_W-1:0]    mcand,
    input  logic [MUL_STEPS-1:0] mplier,
    input  logic [DATA_W-1:0]    addend,
    output logic                 done,
    output logic [DATA_W-1:0]    product
);

    logic [DATA_W-1:0]     acc_reg;
    logic [DATA_W-1:0]     mcand_reg;
    logic [MUL_STEPS-1:0]  mplier_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DATA_W-1:0]     term;
    logic                  last_step;

    assign term      = mplier_reg[0] ? mcand_reg : '0;
    assign last_step = (cnt_reg == STEP_CNT_W'(MUL_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                    busy_reg <= 1'b0;
            end
        end
    end

    // one multiplier bit per cycle; the top bit carries negative weight
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= addend;
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
        end
        else if (busy_reg)
        begin
            acc_reg    <= last_step ? acc_reg - term : acc_reg + term;
            mcand_reg  <= {mcand_reg[DATA_W-2:0], 1'b0};
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### hw/rtl/eps_div.sv
module eps_div
    import eps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TCLK_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [TCLK_W-1:0] quotient
);

    logic [DATA_W-1:0]     rem_reg;
    logic [TCLK_W-1:0]     quo_reg;
    logic [DATA_W-1:0]     dvs_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DATA_W:0]       shifted;
    logic [DATA_W+1:0]     diff;
    logic                  borrow;
    logic                  last_step;

    // restoring divide: dividend bits shift out of quo_reg as quotient bits shift in
    assign shifted   = {rem_reg, quo_reg[TCLK_W-1]};
    assign diff      = {1'b0, shifted} - {2'b00, dvs_reg};
    assign borrow    = diff[DATA_W+1];
    assign last_step = (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= borrow ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
            quo_reg <= {quo_reg[TCLK_W-2:0], ~borrow};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hw/rtl/encoder_period_speed_position.sv
// Overflow and capture beats are taken one per cycle while no sample is in progress
// and produce no result. A sample beat runs a bit-serial multiply and then a
// restoring divide; the result loads once the output register is free, and
// the next beat is taken the cycle after the result loads.
// Reset (rst_n low, asynchronous) clears all counters and capture state and
// loads the register defaults; no result is pending after reset.
module encoder_period_speed_position
    import eps_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               cmd,
    input  logic [CAPTURE_WIDTH-1:0] capture_time,
    input  logic                     chan_b_level,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [FREQ_W-1:0]        frequency_hz,
    output logic [DATA_W-1:0]        total_ticks,
    output logic                     direction,
    output logic signed [DATA_W-1:0] position
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [TCLK_W-1:0]     timer_clock_reg;
    logic [RELOAD_W-1:0]   reload_reg;
    logic [FREQ_W-1:0]     freq_limit_reg;
    logic                  cfg_write;
    logic [1:0]            cfg_idx;

    eps_snap_t             snap;
    logic                  in_accept;
    logic                  sample_accept;
    logic [MUL_STEPS-1:0]  mplier;
    logic                  mul_done;
    logic [DATA_W-1:0]     product;
    logic                  div_done;
    logic [TCLK_W-1:0]     quotient;

    logic [DATA_W-1:0]     ticks_reg;
    logic                  dir_reg;
    logic [DATA_W-1:0]     pos_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_load;
    logic                  freq_zero;
    logic [FREQ_W-1:0]     frequency_hz_reg;
    logic [DATA_W-1:0]     total_ticks_reg;
    logic                  direction_reg;
    logic [DATA_W-1:0]     position_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_clock_reg <= TCLK_RESET;
            reload_reg      <= RELOAD_RESET;
            freq_limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_TIMER_CLOCK: timer_clock_reg <= pwdata[TCLK_W-1:0];
                REG_RELOAD:      reload_reg      <= pwdata[RELOAD_W-1:0];
                REG_FREQ_LIMIT:  freq_limit_reg  <= pwdata[FREQ_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_TIMER_CLOCK: prdata = 32'(timer_clock_reg);
            REG_RELOAD:      prdata = 32'(reload_reg);
            REG_FREQ_LIMIT:  prdata = 32'(freq_limit_reg);
            default:         prdata = '0;
        endcase
    end

    // event intake
    assign in_ready      = (state_reg == S_IDLE);
    assign in_accept     = in_valid && in_ready;
    assign sample_accept = in_accept && (cmd == CMD_SAMPLE);

    eps_track u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .ev_accept    (in_accept),
        .cmd          (cmd),
        .capture_time (capture_time),
        .chan_b_level (chan_b_level),
        .snap         (snap)
    );

    // reload - 3 as a signed 17-bit multiplier
    assign mplier = MUL_STEPS'({1'b0, reload_reg}) - MUL_STEPS'(TICK_LOSS);

    eps_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sample_accept),
        .mcand   (snap.ovf_delta),
        .mplier  (mplier),
        .addend  (snap.cap_delta),
        .done    (mul_done),
        .product (product)
    );

    eps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_done),
        .dividend (timer_clock_reg),
        .divisor  (product),
        .done     (div_done),
        .quotient (quotient)
    );

    // sequencer
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (sample_accept) state_next = S_MUL;
            S_MUL:  if (mul_done)      state_next = S_DIV;
            S_DIV:  if (div_done)      state_next = S_DONE;
            S_DONE: if (out_load)      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            dir_reg <= snap.chan_b;
            pos_reg <= snap.position_next;
        end
        if (mul_done)
            ticks_reg <= product;
    end

    assign freq_zero = (ticks_reg == '0) || (quotient > TCLK_W'(freq_limit_reg));

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            frequency_hz_reg <= freq_zero ? '0 : quotient[FREQ_W-1:0];
            total_ticks_reg  <= ticks_reg;
            direction_reg    <= dir_reg;
            position_reg     <= pos_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frequency_hz = frequency_hz_reg;
    assign total_ticks  = total_ticks_reg;
    assign direction    = direction_reg;
    assign position     = position_reg;

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_sample_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
        sample_accept |=> (state_reg == S_MUL))
        else $error("sample beat did not start the multiply");

    a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_MUL))
        else $error("multiply finished outside its phase");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divide finished outside its phase");

    a_freq_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (frequency_hz_reg <= freq_limit_reg))
        else $error("reported frequency above limit");
`endif

endmodule

### sim/encoder_period_speed_position_tb.sv
`timescale 1ns / 100ps

module encoder_period_speed_position_tb
    import eps_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [FREQ_W-1:0] freq;
        logic [DATA_W-1:0] ticks;
        logic              dir;
        logic [DATA_W-1:0] pos;
    } speed_sample_t;

    class speed_position_scoreboard;
        logic [TCLK_W-1:0]        tclk_hz;
        logic [RELOAD_W-1:0]      reload;
        logic [FREQ_W-1:0]        limit_hz;
        bit [31:0]                ovf_now;
        bit [31:0]                ovf_prev;
        bit [31:0]                ovf_last;
        bit [CAPTURE_WIDTH-1:0]   cap_prev;
        bit [CAPTURE_WIDTH-1:0]   cap_last;
        bit                       chan_b;
        bit [31:0]                edges;
        bit [31:0]                pos_acc;
        speed_sample_t            pending_samples[$];
        int                       errors;

        function new();
            tclk_hz  = TCLK_RESET;
            reload   = RELOAD_RESET;
            limit_hz = LIMIT_RESET;
            ovf_now  = 0;
            ovf_prev = 0;
            ovf_last = 0;
            cap_prev = 0;
            cap_last = 0;
            chan_b   = 0;
            edges    = 0;
            pos_acc  = 0;
            errors   = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_TIMER_CLOCK: tclk_hz  = value[TCLK_W-1:0];
                REG_RELOAD:      reload   = value[RELOAD_W-1:0];
                REG_FREQ_LIMIT:  limit_hz = value[FREQ_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_samples.size();
        endfunction

        function void note_beat(logic [1:0] c, logic [CAPTURE_WIDTH-1:0] t, logic b);
            bit [31:0]     ovf_delta;
            bit [31:0]     per_ovf;
            bit [31:0]     cap_delta;
            bit [31:0]     ticks;
            bit [31:0]     freq;
            speed_sample_t s;
            if (c == CMD_OVERFLOW)
            begin
                ovf_now = ovf_now + 1;
            end
            else if (c == CMD_CAPTURE)
            begin
                cap_prev = cap_last;
                cap_last = t;
                ovf_prev = ovf_last;
                ovf_last = ovf_now;
                chan_b   = b;
                edges    = edges + 1;
            end
            else if (c == CMD_SAMPLE)
            begin
                ovf_delta = ovf_last - ovf_prev;
                per_ovf   = 32'(reload) - 32'(TICK_LOSS);
                cap_delta = 32'(cap_last) - 32'(cap_prev);
                ticks     = ovf_delta * per_ovf + cap_delta;
                freq      = 0;
                if (ticks != 0)
                begin
                    freq = 32'(tclk_hz) / ticks;
                    if (freq > 32'(limit_hz))
                        freq = 0;
                end
                if (chan_b)
                    pos_acc = pos_acc + edges;
                else
                    pos_acc = pos_acc - edges;
                edges   = 0;
                s.freq  = freq[FREQ_W-1:0];
                s.ticks = ticks;
                s.dir   = chan_b;
                s.pos   = pos_acc;
                pending_samples.push_back(s);
            end
        endfunction

        function void check_sample(logic [FREQ_W-1:0] f, logic [DATA_W-1:0] t, logic d,
                                   logic [DATA_W-1:0] p);
            speed_sample_t s;
            if (pending_samples.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected sample beat freq=%0d ticks=%0d dir=%0b pos=%0d",
                             $realtime, f, t, d, $signed(p));
                return;
            end
            s = pending_samples.pop_front();
            if (f !== s.freq || t !== s.ticks || d !== s.dir || p !== s.pos)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $write("%0t: sample mismatch exp freq=%0d ticks=%0d dir=%0b pos=%0d,",
                           $realtime, s.freq, s.ticks, s.dir, $signed(s.pos));
                    $display(" got freq=%0d ticks=%0d dir=%0b pos=%0d",
                             f, t, d, $signed(p));
                end
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               cmd;
    logic [CAPTURE_WIDTH-1:0] capture_time;
    logic                     chan_b_level;
    logic                     out_valid;
    logic                     out_ready;
    logic [FREQ_W-1:0]        frequency_hz;
    logic [DATA_W-1:0]        total_ticks;
    logic                     direction;
    logic signed [DATA_W-1:0] position;

    speed_position_scoreboard sb;
    bit                       hold_req = 1'b0;
    int                       beats_sent = 0;
    int                       burst_left = 0;
    int                       idle_count = 0;
    logic [CAPTURE_WIDTH-1:0] last_cap = '0;

    encoder_period_speed_position u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .capture_time (capture_time),
        .chan_b_level (chan_b_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frequency_hz (frequency_hz),
        .total_ticks  (total_ticks),
        .direction    (direction),
        .position     (position)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // beat monitor: check the older result before noting a new input
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_sample(frequency_hz, total_ticks, direction, position);
            if (in_valid && in_ready)
                sb.note_beat(cmd, capture_time, chan_b_level);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: stall modes change every so often; one long hold on request
    initial
    begin : receiver
        int mode;
        int left;
        mode = 0;
        left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 200);
                end
                left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ((left % 7) < 2);
                endcase
            end
        end
    end

    // all drive tasks start and end on a falling edge
    task automatic drive_beat(input logic [1:0] c, input logic [CAPTURE_WIDTH-1:0] t,
                              input logic b);
        in_valid     <= 1'b1;
        cmd          <= c;
        capture_time <= t;
        chan_b_level <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic offer(input logic [1:0] c, input logic [CAPTURE_WIDTH-1:0] t, input logic b);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(20, 70);
            else
                gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 30);
        end
        drive_beat(c, t, b);
        burst_left--;
        if (c == CMD_CAPTURE)
            last_cap = t;
        if (c != CMD_UNUSED)
            beats_sent++;
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // wait for every expected sample, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input logic [31:0] tclk, input logic [31:0] rld,
                             input logic [31:0] lim);
        settle();
        apb_write(REG_TIMER_CLOCK, tclk);
        apb_write(REG_RELOAD, rld);
        apb_write(REG_FREQ_LIMIT, lim);
    endtask

    // mostly well-formed edge/sample sequences, some random noise
    task automatic run_phase(input int n_beats);
        int                       target;
        int                       n_edges;
        int                       n_ovf;
        logic [CAPTURE_WIDTH-1:0] t;
        target = beats_sent + n_beats;
        while (beats_sent < target)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                offer(2'($urandom_range(0, 3)), CAPTURE_WIDTH'($urandom), 1'($urandom));
            end
            else
            begin
                n_edges = $urandom_range(1, 4);
                repeat (n_edges)
                begin
                    case ($urandom_range(0, 19))
                        0:             n_ovf = $urandom_range(20, 80);
                        1, 2, 3, 4, 5: n_ovf = $urandom_range(3, 8);
                        default:       n_ovf = $urandom_range(0, 2);
                    endcase
                    repeat (n_ovf)
                        offer(CMD_OVERFLOW, CAPTURE_WIDTH'($urandom), 1'($urandom));
                    // near captures give short periods, equal ones zero ticks
                    if ($urandom_range(0, 3) == 0)
                        t = last_cap + CAPTURE_WIDTH'($urandom_range(0, 60));
                    else
                        t = CAPTURE_WIDTH'($urandom);
                    offer(CMD_CAPTURE, t, 1'($urandom));
                end
                offer(CMD_SAMPLE, CAPTURE_WIDTH'($urandom), 1'($urandom));
            end
        end
    endtask

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        cmd          = CMD_OVERFLOW;
        capture_time = '0;
        chan_b_level = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: edge cases first
        offer(CMD_SAMPLE, 16'h0000, 1'b0);          // nothing captured yet
        offer(CMD_UNUSED, 16'hFFFF, 1'b1);          // ignored code
        offer(CMD_CAPTURE, 16'hFFFF, 1'b1);
        offer(CMD_CAPTURE, 16'h0000, 1'b1);         // backward capture delta
        offer(CMD_SAMPLE, 16'hFFFF, 1'b1);
        offer(CMD_OVERFLOW, 16'hFFFF, 1'b1);
        offer(CMD_CAPTURE, 16'h0010, 1'b0);
        offer(CMD_OVERFLOW, 16'h0000, 1'b0);
        offer(CMD_OVERFLOW, 16'h0000, 1'b0);
        offer(CMD_CAPTURE, 16'h0005, 1'b0);
        offer(CMD_SAMPLE, 16'h0000, 1'b0);          // counterclockwise, two overflows
        offer(CMD_CAPTURE, 16'h1234, 1'b1);
        offer(CMD_CAPTURE, 16'h1234, 1'b1);
        offer(CMD_SAMPLE, 16'h0000, 1'b1);          // zero ticks
        offer(CMD_CAPTURE, 16'h0000, 1'b1);
        offer(CMD_CAPTURE, 16'd50, 1'b1);
        offer(CMD_SAMPLE, 16'h0000, 1'b0);          // exactly at the limit
        offer(CMD_CAPTURE, 16'd99, 1'b0);
        offer(CMD_SAMPLE, 16'h0000, 1'b0);          // just above the limit
        offer(CMD_SAMPLE, 16'h0000, 1'b0);          // no edges since last sample
        offer(CMD_UNUSED, 16'h0000, 1'b0);

        configure(32'd200000000, 32'd3, 32'd1000000);   // zero ticks per overflow
        run_phase(40);
        hold_req = 1'b1;
        run_phase(130);

        configure(32'd0, 32'd0, 32'd1);                 // zero clock, reload wraps
        run_phase(165);

        configure(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        run_phase(165);

        configure(32'd1, 32'd65535, 32'd0);
        run_phase(165);

        configure($urandom_range(1000, 200000000), $urandom_range(3, 65535),
                  $urandom_range(1, 1000000));
        run_phase(165);

        configure($urandom_range(100000, 200000000), $urandom_range(1, 200),
                  $urandom_range(1000, 1000000));
        run_phase(165);

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/eps_pkg.sv
hw/rtl/eps_track.sv
hw/rtl/eps_mul.sv
hw/rtl/eps_div.sv
hw/rtl/encoder_period_speed_position.sv
sim/encoder_period_speed_position_tb.sv
